// ===== sv/spq_pkg.sv =====
// Shared types and codes for the sorted priority queue.
package spq_pkg;

    localparam int unsigned DEPTH_DEFAULT = 64;

    localparam logic [1:0] OP_INSERT  = 2'd0;
    localparam logic [1:0] OP_POP     = 2'd1;
    localparam logic [1:0] OP_UPGRADE = 2'd2;
    localparam logic [1:0] OP_CLEAR   = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_POP_EMPTY = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic        [15:0] id;
        logic signed [15:0] prio;
    } t_entry;

endpackage

// ===== sv/spq_ram.sv =====
// Entry memory: one write port, one read port with registered read data.
module spq_ram #(
    parameter int unsigned DEPTH = spq_pkg::DEPTH_DEFAULT
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]   i_wr_addr,
    input  spq_pkg::t_entry            i_wr_data,
    input  logic                       i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]   i_rd_addr,
    output spq_pkg::t_entry            o_rd_data
);

    spq_pkg::t_entry r_mem [DEPTH];
    spq_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/sorted_priority_queue_decrease_key.sv =====
// Top level of the sorted priority queue with decrease-key.
//
// Entries sit in ascending priority order in one memory used as a ring: a head
// pointer marks the front, so clear and pop need no shifting (a pop also reads
// the new front). An insert walks from the tail toward the front, with a memory
// read, then a compare and write, for each entry it moves past. An upgrade scans
// from the front for the target, shifts the tail down by one and then inserts
// as above. Each memory read is registered before it is used. One item is in
// work at a time, and its result is held until it is taken. No clearing pass
// is needed after reset.
module sorted_priority_queue_decrease_key #(
    parameter int unsigned QUEUE_DEPTH = spq_pkg::DEPTH_DEFAULT
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [1:0]                           i_opcode,
    input  logic [15:0]                          i_entry_id,
    input  logic signed [15:0]                   i_entry_priority,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [15:0]                          o_popped_id,
    output logic                                 o_popped_valid,
    output logic [15:0]                          o_front_id,
    output logic signed [15:0]                   o_front_priority,
    output logic                                 o_queue_empty,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]     o_entry_count,
    output logic [1:0]                           o_status
);

    localparam int unsigned AW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW:0] DEPTH_W = (CW + 1)'(QUEUE_DEPTH);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_POP_RD   = 4'd1;
    localparam logic [3:0] S_POP_WB   = 4'd2;
    localparam logic [3:0] S_INS_RD   = 4'd3;
    localparam logic [3:0] S_INS_CMP  = 4'd4;
    localparam logic [3:0] S_UPG_RD   = 4'd5;
    localparam logic [3:0] S_UPG_CMP  = 4'd6;
    localparam logic [3:0] S_REM_RD   = 4'd7;
    localparam logic [3:0] S_REM_WB   = 4'd8;
    localparam logic [3:0] S_FRONT    = 4'd9;
    localparam logic [3:0] S_FRONT_WB = 4'd10;
    localparam logic [3:0] S_OUT      = 4'd11;

    logic [3:0]         r_state, n_state;
    logic [15:0]        r_id, n_id;
    logic signed [15:0] r_prio, n_prio;
    logic [CW-1:0]      r_count, n_count;
    logic [AW-1:0]      r_head, n_head;
    logic [CW-1:0]      r_k, n_k;
    logic [1:0]         r_status, n_status;
    logic [15:0]        r_popped_id, n_popped_id;
    logic               r_popped_valid, n_popped_valid;
    logic [15:0]        r_front_id, n_front_id;
    logic signed [15:0] r_front_prio, n_front_prio;

    logic               rd_en, wr_en;
    logic [AW-1:0]      rd_addr, wr_addr;
    spq_pkg::t_entry    wr_data, rd_data;

    // Logical position from the front to a physical memory address.
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [CW-1:0] pos);
        logic [CW:0] s;
        s = (CW + 1)'(head) + (CW + 1)'(pos);
        if (s >= DEPTH_W) begin
            s = s - DEPTH_W;
        end
        return s[AW-1:0];
    endfunction

    spq_ram #(.DEPTH(QUEUE_DEPTH)) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state        = r_state;
        n_id           = r_id;
        n_prio         = r_prio;
        n_count        = r_count;
        n_head         = r_head;
        n_k            = r_k;
        n_status       = r_status;
        n_popped_id    = r_popped_id;
        n_popped_valid = r_popped_valid;
        n_front_id     = r_front_id;
        n_front_prio   = r_front_prio;
        rd_en          = 1'b0;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = '{id: r_id, prio: r_prio};
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_id           = i_entry_id;
                    n_prio         = i_entry_priority;
                    n_status       = spq_pkg::ST_OK;
                    n_popped_id    = '0;
                    n_popped_valid = 1'b0;
                    n_k            = '0;
                    case (i_opcode)
                        spq_pkg::OP_INSERT: begin
                            if (r_count == CW'(QUEUE_DEPTH)) begin
                                n_status = spq_pkg::ST_FULL;
                                n_state  = S_FRONT;
                            end else begin
                                n_k     = r_count;
                                n_state = S_INS_RD;
                            end
                        end
                        spq_pkg::OP_POP: begin
                            if (r_count == '0) begin
                                n_status = spq_pkg::ST_POP_EMPTY;
                                n_state  = S_FRONT;
                            end else begin
                                n_state = S_POP_RD;
                            end
                        end
                        spq_pkg::OP_UPGRADE: begin
                            n_state = S_UPG_RD;
                        end
                        spq_pkg::OP_CLEAR: begin
                            n_count = '0;
                            n_head  = '0;
                            n_state = S_FRONT;
                        end
                        default: begin
                            n_state = S_FRONT;
                        end
                    endcase
                end
            end
            S_POP_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_head;
                n_state = S_POP_WB;
            end
            S_POP_WB: begin
                n_popped_id    = rd_data.id;
                n_popped_valid = 1'b1;
                n_head         = phys(r_head, CW'(1));
                n_count        = r_count - CW'(1);
                n_state        = S_FRONT;
            end
            // r_k is the free slot; the entry just ahead of it is examined.
            S_INS_RD: begin
                if (r_k == '0) begin
                    wr_en   = 1'b1;
                    wr_addr = phys(r_head, r_k);
                    n_count = r_count + CW'(1);
                    n_state = S_FRONT;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = phys(r_head, r_k - CW'(1));
                    n_state = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                wr_en   = 1'b1;
                wr_addr = phys(r_head, r_k);
                if (rd_data.prio > r_prio) begin
                    wr_data = rd_data;
                    n_k     = r_k - CW'(1);
                    n_state = S_INS_RD;
                end else begin
                    n_count = r_count + CW'(1);
                    n_state = S_FRONT;
                end
            end
            S_UPG_RD: begin
                if (r_k == r_count) begin
                    n_status = spq_pkg::ST_NOT_FOUND;
                    n_state  = S_FRONT;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = phys(r_head, r_k);
                    n_state = S_UPG_CMP;
                end
            end
            S_UPG_CMP: begin
                if (rd_data.id == r_id && rd_data.prio > r_prio) begin
                    n_state = S_REM_RD;
                end else begin
                    n_k     = r_k + CW'(1);
                    n_state = S_UPG_RD;
                end
            end
            // Close the gap at r_k by moving the tail down one slot.
            S_REM_RD: begin
                if (r_k + CW'(1) == r_count) begin
                    n_count = r_count - CW'(1);
                    n_k     = r_count - CW'(1);
                    n_state = S_INS_RD;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = phys(r_head, r_k + CW'(1));
                    n_state = S_REM_WB;
                end
            end
            S_REM_WB: begin
                wr_en   = 1'b1;
                wr_addr = phys(r_head, r_k);
                wr_data = rd_data;
                n_k     = r_k + CW'(1);
                n_state = S_REM_RD;
            end
            S_FRONT: begin
                if (r_count == '0) begin
                    n_front_id   = '0;
                    n_front_prio = '0;
                    n_state      = S_OUT;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_head;
                    n_state = S_FRONT_WB;
                end
            end
            S_FRONT_WB: begin
                n_front_id   = rd_data.id;
                n_front_prio = rd_data.prio;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_head  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_head  <= n_head;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id           <= n_id;
        r_prio         <= n_prio;
        r_k            <= n_k;
        r_status       <= n_status;
        r_popped_id    <= n_popped_id;
        r_popped_valid <= n_popped_valid;
        r_front_id     <= n_front_id;
        r_front_prio   <= n_front_prio;
    end

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = (r_state == S_OUT);
    assign o_popped_id      = r_popped_id;
    assign o_popped_valid   = r_popped_valid;
    assign o_front_id       = r_front_id;
    assign o_front_priority = r_front_prio;
    assign o_queue_empty    = (r_count == '0);
    assign o_entry_count    = r_count;
    assign o_status         = r_status;

endmodule

// ===== sv/spq_checker.sv =====
// Port-level checks for the sorted priority queue, bound to the top level.
module spq_checker #(
    parameter int unsigned QUEUE_DEPTH = spq_pkg::DEPTH_DEFAULT
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_out_valid,
    input logic                             i_out_ready,
    input logic [15:0]                      o_popped_id,
    input logic                             o_popped_valid,
    input logic [15:0]                      o_front_id,
    input logic signed [15:0]               o_front_priority,
    input logic                             o_queue_empty,
    input logic [$clog2(QUEUE_DEPTH+1)-1:0] o_entry_count,
    input logic [1:0]                       o_status
);

    a_empty_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_queue_empty == (o_entry_count == '0)))
        else $error("empty flag disagrees with count");

    a_empty_front_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_queue_empty) |-> (o_front_id == '0 && o_front_priority == '0))
        else $error("front entry not zero on an empty queue");

    a_pop_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_popped_valid) |-> (o_status == spq_pkg::ST_OK))
        else $error("pop transfer reported with an error status");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_status)
            && $stable(o_entry_count) && $stable(o_front_id)))
        else $error("result changed while stalled");

endmodule

bind sorted_priority_queue_decrease_key spq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_spq_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_popped_id      (o_popped_id),
    .o_popped_valid   (o_popped_valid),
    .o_front_id       (o_front_id),
    .o_front_priority (o_front_priority),
    .o_queue_empty    (o_queue_empty),
    .o_entry_count    (o_entry_count),
    .o_status         (o_status)
);
